// ----- hdl/rrts_pkg.sv -----
package rrts_pkg;

  // default number of task table slots
  localparam int TASK_SLOTS_DEF = 16;

  // function codes
  localparam logic [2:0] FUNC_INIT   = 3'd0;
  localparam logic [2:0] FUNC_CREATE = 3'd1;
  localparam logic [2:0] FUNC_TICK   = 3'd2;
  localparam logic [2:0] FUNC_YIELD  = 3'd3;
  localparam logic [2:0] FUNC_EXIT   = 3'd4;

  // request transaction
  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] frame_ptr;
    logic [63:0] stack_top_in;
    logic        alloc_ok;
  } req_t;

  // response transaction
  typedef struct packed {
    logic [63:0] next_sp;
    logic [63:0] next_stack_top;
    logic [3:0]  new_id;
    logic        is_ready;
    logic [63:0] ticks;
    logic [4:0]  count_now;
    logic [3:0]  current_now;
  } rsp_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_READ,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic exec;
    logic step;
    logic rd;
    logic load_rsp;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic do_switch;
    logic hit;
    logic rsp_busy;
  } sts_t;

endpackage

// ----- hdl/rrts_ctrl.sv -----
module rrts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t cmd
);

  rrts_pkg::state_t state;
  rrts_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rrts_pkg::S_IDLE: begin
        if (req_valid) state_next = rrts_pkg::S_EXEC;
      end
      rrts_pkg::S_EXEC: begin
        state_next = sts.do_switch ? rrts_pkg::S_SEARCH : rrts_pkg::S_FINISH;
      end
      rrts_pkg::S_SEARCH: begin
        if (sts.hit) state_next = rrts_pkg::S_READ;
      end
      rrts_pkg::S_READ: begin
        state_next = rrts_pkg::S_FINISH;
      end
      rrts_pkg::S_FINISH: begin
        if (!sts.rsp_busy) state_next = rrts_pkg::S_IDLE;
      end
      default: begin
        state_next = rrts_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_ready    = 1'b0;
    cmd          = '0;
    case (state)
      rrts_pkg::S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      rrts_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      rrts_pkg::S_SEARCH: begin
        cmd.step = 1'b1;
      end
      rrts_pkg::S_READ: begin
        cmd.rd = 1'b1;
      end
      rrts_pkg::S_FINISH: begin
        cmd.load_rsp = !sts.rsp_busy;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/rrts_datapath.sv -----
module rrts_datapath #(
  parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rrts_pkg::req_t req,
  input  rrts_pkg::cmd_t cmd,
  output rrts_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rrts_pkg::rsp_t rsp
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);

  rrts_pkg::req_t   req_q;
  logic             live [TASK_SLOTS];
  logic [63:0]      saved_sp [TASK_SLOTS];
  logic [63:0]      stack_top_tbl [TASK_SLOTS];
  logic [CNT_W-1:0] slot_count;
  logic [IDX_W-1:0] running;
  logic [63:0]      tick_total;
  logic             ready_flag;
  logic [IDX_W-1:0] cand;
  logic [CNT_W-1:0] steps;
  logic             switched;
  logic [IDX_W-1:0] id_q;
  logic [63:0]      sp_q;
  logic [63:0]      top_q;

  logic             is_init;
  logic             is_create;
  logic             is_tick;
  logic             is_yield;
  logic             is_exit;
  logic             not_full;
  logic             create_ok;
  logic [IDX_W-1:0] new_idx;
  logic [IDX_W-1:0] cand_inc;
  logic             sp_we;
  logic [IDX_W-1:0] sp_waddr;
  logic [63:0]      sp_wdata;
  logic             top_we;
  logic [IDX_W-1:0] top_waddr;
  logic [IDX_W+3:0] id_ext;
  logic [CNT_W+4:0] cnt_ext;
  logic [IDX_W+3:0] cur_ext;

  // decode of the held request
  assign is_init   = (req_q.func == rrts_pkg::FUNC_INIT);
  assign is_create = (req_q.func == rrts_pkg::FUNC_CREATE);
  assign is_tick   = (req_q.func == rrts_pkg::FUNC_TICK);
  assign is_yield  = (req_q.func == rrts_pkg::FUNC_YIELD);
  assign is_exit   = (req_q.func == rrts_pkg::FUNC_EXIT);
  assign not_full  = (slot_count < CNT_W'(TASK_SLOTS));
  assign create_ok = is_create && not_full && req_q.alloc_ok;
  assign new_idx   = slot_count[IDX_W-1:0];

  // round-robin step, wrapping at the slot count
  assign cand_inc = (CNT_W'(cand) == slot_count - CNT_W'(1)) ? '0 : cand + IDX_W'(1);

  // status
  assign sts.do_switch = ready_flag && (is_tick || is_yield || is_exit);
  assign sts.hit       = live[cand_inc] || (steps + CNT_W'(1) == slot_count);
  assign sts.rsp_busy  = rsp_valid && !rsp_ready;

  // table write ports
  always_comb begin
    sp_we     = 1'b0;
    sp_waddr  = running;
    sp_wdata  = req_q.frame_ptr;
    top_we    = 1'b0;
    top_waddr = new_idx;
    if (cmd.exec) begin
      if (is_init) begin
        sp_we     = 1'b1;
        sp_waddr  = '0;
        sp_wdata  = '0;
        top_we    = 1'b1;
        top_waddr = '0;
      end else if (create_ok) begin
        sp_we     = 1'b1;
        sp_waddr  = new_idx;
        top_we    = 1'b1;
      end else if ((is_tick || is_yield) && ready_flag) begin
        sp_we     = 1'b1;
      end
    end
  end

  // stack pointer and stack top tables
  always_ff @(posedge clk) begin
    if (sp_we) saved_sp[sp_waddr] <= sp_wdata;
    if (top_we) stack_top_tbl[top_waddr] <= req_q.stack_top_in;
    if (cmd.rd) begin
      sp_q  <= saved_sp[running];
      top_q <= stack_top_tbl[running];
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) live[i] <= 1'b0;
      slot_count <= '0;
      running    <= '0;
      tick_total <= '0;
      ready_flag <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (req_q.func)
          rrts_pkg::FUNC_INIT: begin
            live[0]    <= 1'b1;
            slot_count <= CNT_W'(1);
            running    <= '0;
            ready_flag <= 1'b1;
          end
          rrts_pkg::FUNC_CREATE: begin
            if (not_full) begin
              slot_count    <= slot_count + CNT_W'(1);
              live[new_idx] <= req_q.alloc_ok;
            end
          end
          rrts_pkg::FUNC_TICK: begin
            if (ready_flag) tick_total <= tick_total + 64'd1;
          end
          rrts_pkg::FUNC_EXIT: begin
            if (ready_flag) live[running] <= 1'b0;
          end
          default: begin
            tick_total <= tick_total;
          end
        endcase
      end
      if (cmd.step && sts.hit) running <= cand_inc;
    end
  end

  // request hold and search registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_q <= req;
    if (cmd.exec) begin
      cand     <= running;
      steps    <= '0;
      switched <= sts.do_switch;
      id_q     <= create_ok ? new_idx : '0;
    end else if (cmd.step) begin
      cand  <= cand_inc;
      steps <= steps + CNT_W'(1);
    end
  end

  // response register
  assign id_ext  = {4'b0000, id_q};
  assign cnt_ext = {5'b00000, slot_count};
  assign cur_ext = {4'b0000, running};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp.next_sp        <= switched ? sp_q : req_q.frame_ptr;
      rsp.next_stack_top <= switched ? top_q : 64'd0;
      rsp.new_id         <= id_ext[3:0];
      rsp.is_ready       <= ready_flag;
      rsp.ticks          <= tick_total;
      rsp.count_now      <= cnt_ext[4:0];
      rsp.current_now    <= cur_ext[3:0];
    end
  end

  // running task always lies inside the table once ready
  a_running_in_range: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> (CNT_W'(running) < slot_count))
    else $error("running task outside slot count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CNT_W'(TASK_SLOTS))
    else $error("slot count above table size");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (steps < slot_count))
    else $error("search ran past slot count");

  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    ready_flag |=> ready_flag)
    else $error("ready flag dropped");

endmodule

// ----- hdl/round_robin_task_switcher.sv -----
// Sequence: an item that causes no switch is accepted, executed and then finished, its
// result registered once the response register is free. A tick, yield or exit once ready
// also runs the round-robin search, which visits one slot per cycle, and a table read
// before it finishes; the next item is taken only once the last one has finished.
// Reset (rst, synchronous): controller idle, live flags, counts, current task, tick
// counter and ready flag cleared; stack tables are not cleared and hold junk until written.
module round_robin_task_switcher #(
  parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rrts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rrts_pkg::rsp_t rsp
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  // sequencer
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // task table and scheduler registers
  rrts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
